FILE: hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg - shared definitions for the button press classifier
// Register indexes, result codes, reset values and the interface structs.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int TICK_WIDTH_DEF = 32;
	localparam int CFG_W          = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int KIND_W         = 4;
	localparam int S_TDATA_W      = 40;
	localparam int M_TDATA_W      = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE_PULSATING       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_GAP_TIME       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_PRESS_TIME = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 32'd20;
	localparam logic [CFG_W-1:0] RESET_GAP_RST = 32'd300;
	localparam logic [CFG_W-1:0] LONG_RST      = 32'd1000;
	localparam logic [CFG_W-1:0] VERY_LONG_RST = 32'd3000;

	// press_kind codes
	localparam logic [KIND_W-1:0] KIND_NONE      = 4'd0;
	localparam logic [KIND_W-1:0] KIND_SHORT     = 4'd1;
	localparam logic [KIND_W-1:0] KIND_DOUBLE    = 4'd2;
	localparam logic [KIND_W-1:0] KIND_TRIPLE    = 4'd3;
	localparam logic [KIND_W-1:0] KIND_MULTIPLE  = 4'd4;
	localparam logic [KIND_W-1:0] KIND_LONG      = 4'd5;
	localparam logic [KIND_W-1:0] KIND_VERY_LONG = 4'd6;
	localparam logic [KIND_W-1:0] KIND_RELEASE   = 4'd7;
	localparam logic [KIND_W-1:0] KIND_PULSATING = 4'd8;

	// operation codes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	typedef struct packed {
		logic             mode_pulsating;
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] reset_gap_time;
		logic [CFG_W-1:0] long_press_time;
		logic [CFG_W-1:0] very_long_press_time;
	} cfg_t;

	typedef struct packed {
		logic        operation;
		logic        level_pressed;
		logic [31:0] time_stamp;
	} item_t;

endpackage

FILE: hdl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier - debounced button multi-click classifier
// Time-stamped edge and poll items in, one press classification per poll out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one transaction per item. s_tuser is the operation
//   (0 edge report, 1 poll); s_tdata carries the new level and time stamp.
//   Master channel m_*: one transaction per poll, press_kind in m_tdata.
//   Edge items update the debounce state and produce no transaction.
//   Config channel cfg_*: register writes, always ready; write only while
//   the block is idle.
// Result path: a poll passes the input register, then the result register,
//   before its result is presented.
// Throughput: one item per cycle while no poll stalls; the state update is a
//   single pass of a few subtract/compare operations between input and result registers.
// Reset: arst_n clears the item and result valid flags and loads the
//   register and state reset values; no clearing pass is needed.
// Stall: while m_tready is low with a result waiting, a poll held in the
//   input register waits and s_tready drops; edge items still drain.
// ----------------------------------------------------------------------------
module button_press_classifier #(
	parameter int TICK_WIDTH = bpc_pkg::TICK_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bpc_pkg::S_TDATA_W-1:0] s_tdata,  // [0] level_pressed, [32:1] time_stamp
	input  logic                          s_tuser,  // [0] operation
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bpc_pkg::M_TDATA_W-1:0] m_tdata,  // [3:0] press_kind
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]     cfg_data
);

	bpc_pkg::cfg_t  cfg;
	bpc_pkg::item_t item_s1;
	logic           valid_s1;
	logic           advance;
	logic           is_poll;
	logic [bpc_pkg::KIND_W-1:0] kind;
	logic [bpc_pkg::KIND_W-1:0] kind_q;
	logic           out_valid_q;

	assign cfg_ready = 1'b1;

	bpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// A poll moves on only if the result register is free or being emptied;
	// an edge item has no result and always moves on.
	assign is_poll  = (item_s1.operation == bpc_pkg::OP_POLL);
	assign advance  = valid_s1 & (~is_poll | ~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation     <= s_tuser;
			item_s1.level_pressed <= s_tdata[0];
			item_s1.time_stamp    <= s_tdata[32:1];
		end
	end

	bpc_core #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.update (advance),
		.cfg    (cfg),
		.kind   (kind)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_poll) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_poll)
			kind_q <= kind;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(bpc_pkg::M_TDATA_W - bpc_pkg::KIND_W){1'b0}}, kind_q};

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_poll_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_poll) |=> m_tvalid)
		else $error("poll left the core without a result");

	a_edge_never_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !is_poll) |-> s_tready)
		else $error("edge item held back");

	a_blocked_poll_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_poll && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted over a blocked poll");

	a_kind_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (kind_q <= bpc_pkg::KIND_PULSATING))
		else $error("press_kind out of range");

endmodule

FILE: hdl/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpc_cfg_regs - configuration register file
// Takes indexed writes and presents the settings as one struct.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [bpc_pkg::CFG_W-1:0]     wr_data,
	output bpc_pkg::cfg_t                 cfg
);

	bpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_pulsating       <= 1'b0;
			cfg_q.debounce_time        <= bpc_pkg::DEBOUNCE_RST;
			cfg_q.reset_gap_time       <= bpc_pkg::RESET_GAP_RST;
			cfg_q.long_press_time      <= bpc_pkg::LONG_RST;
			cfg_q.very_long_press_time <= bpc_pkg::VERY_LONG_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				bpc_pkg::REG_MODE_PULSATING:       cfg_q.mode_pulsating <= wr_data[0];
				bpc_pkg::REG_DEBOUNCE_TIME:        cfg_q.debounce_time <= wr_data;
				bpc_pkg::REG_RESET_GAP_TIME:       cfg_q.reset_gap_time <= wr_data;
				bpc_pkg::REG_LONG_PRESS_TIME:      cfg_q.long_press_time <= wr_data;
				bpc_pkg::REG_VERY_LONG_PRESS_TIME: cfg_q.very_long_press_time <= wr_data;
				default: ; // unknown index: ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core - debounce state and press classification
// Holds the edge/press state and works one registered item per cycle while update is high.
// ----------------------------------------------------------------------------
module bpc_core #(
	parameter int TICK_WIDTH = bpc_pkg::TICK_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpc_pkg::item_t             item,
	input  logic                       update,
	input  bpc_pkg::cfg_t              cfg,
	output logic [bpc_pkg::KIND_W-1:0] kind
);

	localparam int TW = TICK_WIDTH;
	localparam int CW = (TICK_WIDTH > bpc_pkg::CFG_W) ? TICK_WIDTH : bpc_pkg::CFG_W;

	function automatic logic [CW-1:0] tdiff(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW-1:0] d;
		d = a - b;
		return CW'(d);
	endfunction

	logic          level_q;
	logic [TW-1:0] edge_q [2];
	logic [TW-1:0] acc_q  [2];
	logic [7:0]    pulse_q;
	logic          open_q;

	logic          level_d;
	logic [TW-1:0] edge_d [2];
	logic [TW-1:0] acc_d  [2];
	logic [7:0]    pulse_d;
	logic          open_d;

	logic [TW-1:0] t;
	logic [CW-1:0] deb, gap, lng, vlng, eff_gap;
	logic          lvl, oth;
	logic [CW-1:0] d_edge;

	assign t    = TW'(item.time_stamp);
	assign deb  = CW'(cfg.debounce_time);
	assign gap  = CW'(cfg.reset_gap_time);
	assign lng  = CW'(cfg.long_press_time);
	assign vlng = CW'(cfg.very_long_press_time);
	assign eff_gap = (gap < deb) ? deb : gap;
	assign lvl = item.level_pressed;
	assign oth = ~item.level_pressed;
	assign d_edge = tdiff(t, edge_q[oth]);

	always_comb begin
		level_d = level_q;
		edge_d  = edge_q;
		acc_d   = acc_q;
		pulse_d = pulse_q;
		open_d  = open_q;
		kind    = bpc_pkg::KIND_NONE;
		if (item.operation == bpc_pkg::OP_EDGE) begin
			if (level_q != lvl) begin
				edge_d[lvl] = t;
				level_d     = lvl;
				if (d_edge >= deb) begin
					if (lvl)
						open_d = 1'b1;
					acc_d[oth] = edge_q[oth];
					// release: held time equals d_edge, press start is edge_q[1]
					if (!lvl && (cfg.mode_pulsating || d_edge < vlng)) begin
						if (tdiff(edge_q[1], acc_q[0]) > eff_gap)
							pulse_d = 8'd1;
						else if (pulse_q != 8'hFF)
							pulse_d = pulse_q + 8'd1;
					end
				end
			end
		end else if (!cfg.mode_pulsating) begin
			if (level_q && pulse_q == 8'd0 && tdiff(t, edge_q[1]) > vlng && open_q) begin
				kind    = bpc_pkg::KIND_VERY_LONG;
				open_d  = 1'b0;
				pulse_d = 8'd0;
			end else if (pulse_q == 8'd1 && tdiff(edge_q[0], acc_q[1]) > lng) begin
				kind    = bpc_pkg::KIND_LONG;
				open_d  = 1'b0;
				pulse_d = 8'd0;
			end else if (!level_q && pulse_q == 8'd0 && tdiff(t, edge_q[0]) > deb
					&& !open_q) begin
				kind   = bpc_pkg::KIND_RELEASE;
				open_d = 1'b1;
			end else if (tdiff(t, acc_q[1]) > eff_gap && pulse_q != 8'd0) begin
				case (pulse_q)
					8'd1:    kind = bpc_pkg::KIND_SHORT;
					8'd2:    kind = bpc_pkg::KIND_DOUBLE;
					8'd3:    kind = bpc_pkg::KIND_TRIPLE;
					default: kind = bpc_pkg::KIND_MULTIPLE;
				endcase
				open_d  = 1'b0;
				pulse_d = 8'd0;
			end
		end else begin
			if (pulse_q != 8'd0 && !level_q && tdiff(t, edge_q[0]) > eff_gap) begin
				kind    = bpc_pkg::KIND_RELEASE;
				pulse_d = 8'd0;
			end else if (pulse_q != 8'd0) begin
				kind = bpc_pkg::KIND_PULSATING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= 1'b0;
			edge_q[0] <= '0;
			edge_q[1] <= '0;
			acc_q[0]  <= TW'(1);
			acc_q[1]  <= '0;
			pulse_q   <= 8'd0;
			open_q    <= 1'b1;
		end else if (update) begin
			level_q <= level_d;
			edge_q  <= edge_d;
			acc_q   <= acc_d;
			pulse_q <= pulse_d;
			open_q  <= open_d;
		end
	end

endmodule
